// File: hw/rtl/kebd_pkg.sv
// Shared types, constants and register codes for the keyed event burst detector.
package kebd_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 16;
  localparam int unsigned KEY_BITS_DEF      = 32;

  localparam int unsigned MS_PER_SEC  = 1000;
  localparam int unsigned TOPIC_W     = 32;
  localparam int unsigned TIME_W      = 48;
  localparam int unsigned COUNT_W     = 16;
  localparam int unsigned WIN_W       = 16;
  // 65535 s * 1000 ms fits in 26 bits.
  localparam int unsigned SPAN_W      = 26;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned IN_DATA_W   = 128;
  localparam int unsigned OUT_DATA_W  = 24;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_COUNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SEC = 2'd2;

  localparam logic ACT_TRACK = 1'b0;
  localparam logic ACT_CLEAR = 1'b1;

  typedef struct packed {
    logic              enable;
    logic [COUNT_W-1:0] min_count;
    logic [SPAN_W-1:0]  span_ms;
  } cfg_t;

  typedef struct packed {
    logic              action;
    logic [TOPIC_W-1:0] topic_key;
    logic [TIME_W-1:0]  now_ms;
    logic [TIME_W-1:0]  detect_stamp_ms;
  } item_t;

  typedef struct packed {
    logic              detected;
    logic [COUNT_W-1:0] publish_count;
  } result_t;

  // Per-entry counting state, kept apart from the keys so a clear leaves keys intact.
  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [TIME_W-1:0]  win_begin;
    logic               flagged;
    logic [TIME_W-1:0]  flag_stamp;
  } entry_state_t;

  localparam int unsigned ENTRY_STATE_W = $bits(entry_state_t);

endpackage

// File: hw/rtl/kebd_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module kebd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/kebd_core.sv
// Table engine: scans the key and state memories, updates or allocates an entry, clears.
module kebd_core import kebd_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int unsigned KEY_BITS      = KEY_BITS_DEF
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  item_t   item_i,
  output logic    res_valid_o,
  input  logic    res_ready_i,
  output result_t res_o
);

  localparam int unsigned IW   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CNTW = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned CPW  = (KEY_BITS < TOPIC_W) ? KEY_BITS : TOPIC_W;
  localparam logic [CNTW-1:0] FULL_COUNT = CNTW'(TABLE_ENTRIES);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CALC,
    ST_HIT,
    ST_NEW,
    ST_CLEAR,
    ST_RESP
  } state_e;

  state_e           state_q, state_d;
  logic [CNTW-1:0]  used_q, used_d;
  logic [CNTW-1:0]  issue_q, issue_d;
  logic [CNTW-1:0]  clr_q, clr_d;
  logic             rvalid_q, rvalid_d;
  logic [IW-1:0]    raddr_q;
  result_t          res_q, res_d;

  // Item and scan payload.
  logic [KEY_BITS-1:0] key_q, key_d;
  logic [TIME_W-1:0]   now_q, now_d;
  logic [TIME_W-1:0]   stamp_q, stamp_d;
  logic [IW-1:0]       hit_idx_q, hit_idx_d;
  entry_state_t        hit_q, hit_d;
  logic                expired_q, expired_d;
  logic                unf_found_q, unf_found_d;
  logic [IW-1:0]       unf_idx_q, unf_idx_d;
  logic [TIME_W-1:0]   unf_start_q, unf_start_d;
  logic                stp_found_q, stp_found_d;
  logic [IW-1:0]       stp_idx_q, stp_idx_d;
  logic [TIME_W-1:0]   stp_val_q, stp_val_d;

  // Memory ports.
  logic                rd_en;
  logic [KEY_BITS-1:0] key_rd;
  logic [ENTRY_STATE_W-1:0] st_rd_raw;
  entry_state_t        st_rd;
  logic                key_we;
  logic                st_we;
  logic [IW-1:0]       st_waddr;
  entry_state_t        st_wdata;
  logic [IW-1:0]       new_slot;
  logic                full;
  logic                match;
  logic [COUNT_W-1:0]  hit_count;
  logic                hit_reach;

  assign st_rd = entry_state_t'(st_rd_raw);
  assign full  = (used_q == FULL_COUNT);
  assign match = rvalid_q && (key_rd == key_q);
  assign rd_en = (state_q == ST_SCAN) && (issue_q != used_q);

  always_comb begin
    if (!full) begin
      new_slot = used_q[IW-1:0];
    end else if (unf_found_q) begin
      new_slot = unf_idx_q;
    end else begin
      new_slot = stp_idx_q;
    end
  end

  always_comb begin
    if (expired_q) begin
      hit_count = COUNT_W'(1);
    end else if (hit_q.count != COUNT_MAX) begin
      hit_count = hit_q.count + COUNT_W'(1);
    end else begin
      hit_count = hit_q.count;
    end
    hit_reach = (hit_count >= cfg_i.min_count);
  end

  always_comb begin
    state_d     = state_q;
    used_d      = used_q;
    issue_d     = issue_q;
    clr_d       = clr_q;
    rvalid_d    = rd_en;
    res_d       = res_q;
    key_d       = key_q;
    now_d       = now_q;
    stamp_d     = stamp_q;
    hit_idx_d   = hit_idx_q;
    hit_d       = hit_q;
    expired_d   = expired_q;
    unf_found_d = unf_found_q;
    unf_idx_d   = unf_idx_q;
    unf_start_d = unf_start_q;
    stp_found_d = stp_found_q;
    stp_idx_d   = stp_idx_q;
    stp_val_d   = stp_val_q;
    key_we      = 1'b0;
    st_we       = 1'b0;
    st_waddr    = new_slot;
    st_wdata    = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          key_d       = KEY_BITS'(item_i.topic_key[CPW-1:0]);
          now_d       = item_i.now_ms;
          stamp_d     = item_i.detect_stamp_ms;
          issue_d     = '0;
          clr_d       = '0;
          unf_found_d = 1'b0;
          stp_found_d = 1'b0;
          res_d       = '0;
          if (item_i.action == ACT_CLEAR) begin
            state_d = (used_q != '0) ? ST_CLEAR : ST_RESP;
          end else if (cfg_i.enable) begin
            state_d = ST_SCAN;
          end else begin
            state_d = ST_RESP;
          end
        end
      end
      ST_SCAN: begin
        if (rd_en) begin
          issue_d = issue_q + CNTW'(1);
        end
        if (rvalid_q) begin
          if (!st_rd.flagged && (!unf_found_q || st_rd.win_begin < unf_start_q)) begin
            unf_found_d = 1'b1;
            unf_idx_d   = raddr_q;
            unf_start_d = st_rd.win_begin;
          end
          if (!stp_found_q || st_rd.flag_stamp < stp_val_q) begin
            stp_found_d = 1'b1;
            stp_idx_d   = raddr_q;
            stp_val_d   = st_rd.flag_stamp;
          end
        end
        if (match) begin
          hit_idx_d = raddr_q;
          hit_d     = st_rd;
          state_d   = ST_CALC;
        end else if (issue_q == used_q) begin
          state_d = ST_NEW;
        end
      end
      ST_CALC: begin
        expired_d = (now_q > hit_q.win_begin) &&
                    ((now_q - hit_q.win_begin) > TIME_W'(cfg_i.span_ms));
        state_d   = ST_HIT;
      end
      ST_HIT: begin
        st_we                 = 1'b1;
        st_waddr              = hit_idx_q;
        st_wdata.count        = hit_count;
        st_wdata.win_begin    = expired_q ? now_q : hit_q.win_begin;
        st_wdata.flagged      = hit_q.flagged || hit_reach;
        st_wdata.flag_stamp   = (!hit_q.flagged && hit_reach) ? stamp_q : hit_q.flag_stamp;
        res_d.detected        = hit_q.flagged || hit_reach;
        res_d.publish_count   = hit_count;
        state_d               = ST_RESP;
      end
      ST_NEW: begin
        key_we                = 1'b1;
        st_we                 = 1'b1;
        st_waddr              = new_slot;
        st_wdata.count        = COUNT_W'(1);
        st_wdata.win_begin    = now_q;
        st_wdata.flagged      = (cfg_i.min_count == COUNT_W'(1));
        st_wdata.flag_stamp   = (cfg_i.min_count == COUNT_W'(1)) ? stamp_q : '0;
        res_d.detected        = (cfg_i.min_count == COUNT_W'(1));
        res_d.publish_count   = COUNT_W'(1);
        if (!full) begin
          used_d = used_q + CNTW'(1);
        end
        state_d = ST_RESP;
      end
      ST_CLEAR: begin
        st_we    = 1'b1;
        st_waddr = clr_q[IW-1:0];
        st_wdata = '0;
        clr_d    = clr_q + CNTW'(1);
        if (clr_d == used_q) begin
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      used_q   <= '0;
      issue_q  <= '0;
      clr_q    <= '0;
      rvalid_q <= 1'b0;
      res_q    <= '0;
    end else begin
      state_q  <= state_d;
      used_q   <= used_d;
      issue_q  <= issue_d;
      clr_q    <= clr_d;
      rvalid_q <= rvalid_d;
      res_q    <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    raddr_q     <= issue_q[IW-1:0];
    key_q       <= key_d;
    now_q       <= now_d;
    stamp_q     <= stamp_d;
    hit_idx_q   <= hit_idx_d;
    hit_q       <= hit_d;
    expired_q   <= expired_d;
    unf_found_q <= unf_found_d;
    unf_idx_q   <= unf_idx_d;
    unf_start_q <= unf_start_d;
    stp_found_q <= stp_found_d;
    stp_idx_q   <= stp_idx_d;
    stp_val_q   <= stp_val_d;
  end

  kebd_ram #(
    .WIDTH (KEY_BITS),
    .DEPTH (TABLE_ENTRIES)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (new_slot),
    .wdata_i (key_q),
    .re_i    (rd_en),
    .raddr_i (issue_q[IW-1:0]),
    .rdata_o (key_rd)
  );

  kebd_ram #(
    .WIDTH (ENTRY_STATE_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .re_i    (rd_en),
    .raddr_i (issue_q[IW-1:0]),
    .rdata_o (st_rd_raw)
  );

  assign in_ready_o  = (state_q == ST_IDLE);
  assign res_valid_o = (state_q == ST_RESP);
  assign res_o       = res_q;

`ifndef SYNTHESIS
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= FULL_COUNT)
    else $error("table fill count exceeds the table size");

  a_used_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (used_q != $past(used_q)) |-> (used_q == $past(used_q) + CNTW'(1)))
    else $error("table fill count moved by other than one");

  a_hit_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_HIT) |-> (CNTW'(hit_idx_q) < used_q))
    else $error("hit update addresses an unused entry");

  a_clear_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_RESP) && ($past(state_q) == ST_CLEAR)) |->
      (!res_q.detected && (res_q.publish_count == '0)))
    else $error("clear returned a non-zero result");
`endif

endmodule

// File: hw/rtl/keyed_event_burst_detector.sv
// Top level of the keyed event burst detector: stream ports, registers, result buffer.
//
// One item is worked on at a time. A track transfer scans the used part of the table, up to
// the first matching key, one entry per cycle through the single read port of the key and
// state memories; for a new key it then allocates an entry, for a known one it updates it.
// A clear writes one used entry per cycle, and a track while disabled goes straight to its
// result. A finished result waits in an output register, and the next input transfer can
// be taken in the cycle after the result moves there. The table needs no initialisation
// after reset.
module keyed_event_burst_detector import kebd_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int unsigned KEY_BITS      = KEY_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration write port.
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // Input stream.
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // tdata: topic_key [31:0], now_ms [79:32], detect_stamp_ms [127:80]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // tuser: action [0]
  input  logic                  s_axis_tuser_i,
  // Result stream.
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // tdata: detected [0], publish_count [16:1], zero padding [23:17]
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o
);

  logic               enable_q, enable_d;
  logic [COUNT_W-1:0] min_count_q, min_count_d;
  logic [WIN_W-1:0]   window_sec_q, window_sec_d;
  logic [SPAN_W-1:0]  span_q, span_d;
  logic                  out_valid_q, out_valid_d;
  logic [OUT_DATA_W-1:0] out_data_q, out_data_d;

  cfg_t    cfg;
  item_t   item;
  result_t res;
  logic    res_valid;
  logic    res_ready;

  always_comb begin
    enable_d     = enable_q;
    min_count_d  = min_count_q;
    window_sec_d = window_sec_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ENABLE:     enable_d     = cfg_data_i[0];
        REG_MIN_COUNT:  min_count_d  = cfg_data_i[COUNT_W-1:0];
        REG_WINDOW_SEC: window_sec_d = cfg_data_i[WIN_W-1:0];
        default: begin
        end
      endcase
    end
    span_d = SPAN_W'(32'(window_sec_q) * MS_PER_SEC);
  end

  assign cfg.enable    = enable_q;
  assign cfg.min_count = min_count_q;
  assign cfg.span_ms   = span_q;

  assign item.action          = s_axis_tuser_i;
  assign item.topic_key       = s_axis_tdata_i[TOPIC_W-1:0];
  assign item.now_ms          = s_axis_tdata_i[TOPIC_W +: TIME_W];
  assign item.detect_stamp_ms = s_axis_tdata_i[TOPIC_W+TIME_W +: TIME_W];

  kebd_core #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .KEY_BITS      (KEY_BITS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .item_i      (item),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // The result register frees itself in the cycle the downstream side takes its transfer.
  assign res_ready = !out_valid_q || m_axis_tready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
      out_data_d  = OUT_DATA_W'({res.publish_count, res.detected});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q     <= 1'b1;
      min_count_q  <= COUNT_W'(3);
      window_sec_q <= WIN_W'(10);
      span_q       <= SPAN_W'(10 * MS_PER_SEC);
      out_valid_q  <= 1'b0;
    end else begin
      enable_q     <= enable_d;
      min_count_q  <= min_count_d;
      window_sec_q <= window_sec_d;
      span_q       <= span_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

// File: test/tb.sv
// Self-checking testbench for the keyed event burst detector: directed table, then random phases.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import kebd_pkg::*;

  localparam int unsigned NUM_SLOTS   = TABLE_ENTRIES_DEF;
  localparam int unsigned KEY_POOL    = 24;
  localparam int unsigned RAND_PHASES = 8;
  localparam int unsigned PHASE_ITEMS = 125;
  localparam logic [TIME_W-1:0]  TIME_MAX = '1;

  typedef enum logic {ROW_EVENT, ROW_REG} row_kind_e;

  typedef struct {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    item_t                 ev;
    bit                    typed;
    result_t               want;
  } stim_row_t;

  logic                  clk_i           = 1'b0;
  logic                  rst_ni          = 1'b0;
  logic                  cfg_we_i        = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i       = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i      = '0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [IN_DATA_W-1:0]  s_axis_tdata_i  = '0;
  logic                  s_axis_tuser_i  = ACT_TRACK;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;

  // Shadow copy of the registers and the key table.
  logic                  cfg_enable = 1'b1;
  logic [COUNT_W-1:0]    cfg_min    = 16'd3;
  logic [WIN_W-1:0]      cfg_win    = 16'd10;
  int unsigned           tbl_used   = 0;
  logic [TOPIC_W-1:0]    tbl_key   [NUM_SLOTS] = '{default: '0};
  logic [COUNT_W-1:0]    tbl_count [NUM_SLOTS] = '{default: '0};
  logic [TIME_W-1:0]     tbl_start [NUM_SLOTS] = '{default: '0};
  logic                  tbl_flag  [NUM_SLOTS] = '{default: 1'b0};
  logic [TIME_W-1:0]     tbl_stamp [NUM_SLOTS] = '{default: '0};

  result_t     burst_verdicts_due [$];
  stim_row_t   directed_rows [$];
  int unsigned fault_cnt = 0;
  bit          calm      = 1'b0;

  keyed_event_burst_detector u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [TIME_W-1:0] rand48();
    return {16'($urandom), 32'($urandom)};
  endfunction

  function automatic item_t mk_event(logic action, logic [TOPIC_W-1:0] key,
                                     logic [TIME_W-1:0] now, logic [TIME_W-1:0] stamp);
    item_t ev;
    ev.action          = action;
    ev.topic_key       = key;
    ev.now_ms          = now;
    ev.detect_stamp_ms = stamp;
    return ev;
  endfunction

  // Works out the verdict of one accepted transfer and updates the shadow table.
  function automatic result_t predict_publish(item_t ev);
    result_t           verdict;
    int                slot;
    int                best;
    bit                spare_found;
    logic [TIME_W-1:0] oldest;
    logic [TIME_W-1:0] span;
    verdict = '0;
    if (ev.action == ACT_CLEAR) begin
      for (int i = 0; i < tbl_used; i++) begin
        tbl_count[i] = '0;
        tbl_start[i] = '0;
        tbl_flag[i]  = 1'b0;
        tbl_stamp[i] = '0;
      end
      return verdict;
    end
    if (!cfg_enable) return verdict;
    span = TIME_W'(cfg_win) * TIME_W'(MS_PER_SEC);
    slot = -1;
    for (int i = 0; i < tbl_used; i++) begin
      if (slot < 0 && tbl_key[i] == ev.topic_key) slot = i;
    end
    if (slot < 0) begin
      if (tbl_used < NUM_SLOTS) begin
        slot = tbl_used;
        tbl_used++;
      end else begin
        // Prefer the unmarked entry with the oldest window, else the oldest mark.
        spare_found = 1'b0;
        best        = 0;
        oldest      = '0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (!tbl_flag[i] && (!spare_found || tbl_start[i] < oldest)) begin
            oldest      = tbl_start[i];
            best        = i;
            spare_found = 1'b1;
          end
        end
        if (!spare_found) begin
          best   = 0;
          oldest = tbl_stamp[0];
          for (int i = 1; i < NUM_SLOTS; i++) begin
            if (tbl_stamp[i] < oldest) begin
              oldest = tbl_stamp[i];
              best   = i;
            end
          end
        end
        slot = best;
      end
      tbl_key[slot]   = ev.topic_key;
      tbl_count[slot] = 16'd1;
      tbl_start[slot] = ev.now_ms;
      tbl_flag[slot]  = (cfg_min == 16'd1);
      tbl_stamp[slot] = (cfg_min == 16'd1) ? ev.detect_stamp_ms : '0;
    end else begin
      if (ev.now_ms > tbl_start[slot] && ev.now_ms - tbl_start[slot] > span) begin
        tbl_count[slot] = 16'd1;
        tbl_start[slot] = ev.now_ms;
      end else if (tbl_count[slot] != COUNT_MAX) begin
        tbl_count[slot] = tbl_count[slot] + 16'd1;
      end
      if (!tbl_flag[slot] && tbl_count[slot] >= cfg_min) begin
        tbl_flag[slot]  = 1'b1;
        tbl_stamp[slot] = ev.detect_stamp_ms;
      end
    end
    verdict.detected      = tbl_flag[slot];
    verdict.publish_count = tbl_count[slot];
    return verdict;
  endfunction

  function automatic void add_event(item_t ev, bit typed, logic det, logic [COUNT_W-1:0] cnt);
    stim_row_t row;
    row.kind                  = ROW_EVENT;
    row.reg_idx               = '0;
    row.reg_val               = '0;
    row.ev                    = ev;
    row.typed                 = typed;
    row.want.detected         = det;
    row.want.publish_count    = cnt;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    stim_row_t row;
    row.kind    = ROW_REG;
    row.reg_idx = idx;
    row.reg_val = val;
    row.ev      = '0;
    row.typed   = 1'b0;
    row.want    = '0;
    directed_rows.push_back(row);
  endfunction

  // Called right after a rising edge; returns at the edge where the transfer happened.
  task automatic push_event(item_t ev, bit typed, result_t want);
    result_t verdict;
    if (!calm && $urandom_range(0, 99) < 12) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {ev.detect_stamp_ms, ev.now_ms, ev.topic_key};
    s_axis_tuser_i  <= ev.action;
    do @(posedge clk_i); while (!s_axis_tready_o);
    verdict = predict_publish(ev);
    burst_verdicts_due.push_back(typed ? want : verdict);
  endtask

  // Holds the input back until every outstanding verdict has been taken.
  task automatic settle();
    s_axis_tvalid_i <= 1'b0;
    while (burst_verdicts_due.size() != 0) @(posedge clk_i);
    repeat (NUM_SLOTS + 8) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_ENABLE:     cfg_enable = val[0];
      REG_MIN_COUNT:  cfg_min    = val;
      REG_WINDOW_SEC: cfg_win    = val;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // Result side: random back-pressure and comparison against the oldest verdict.
  initial begin
    result_t     got;
    result_t     want;
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
        got.detected      = m_axis_tdata_o[0];
        got.publish_count = m_axis_tdata_o[16:1];
        if (burst_verdicts_due.size() == 0) begin
          $error("result transfer with nothing pending, tdata %h", m_axis_tdata_o);
          fault_cnt++;
        end else begin
          want = burst_verdicts_due.pop_front();
          if (got.detected !== want.detected) begin
            $error("detected: expected %0d, got %0d", want.detected, got.detected);
            fault_cnt++;
          end
          if (got.publish_count !== want.publish_count) begin
            $error("publish_count: expected %0d, got %0d",
                   want.publish_count, got.publish_count);
            fault_cnt++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready_i <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < 1) begin
        stall_left = $urandom_range(0, 11);
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  initial begin
    #250_000_000;
    $display("keyed_event_burst_detector verification failed");
    $finish;
  end

  initial begin
    item_t                 ev;
    result_t               none;
    logic [TIME_W-1:0]     clock_ms;
    int unsigned           n;
    int unsigned           roll;
    logic [TOPIC_W-1:0]    key_pool [KEY_POOL];
    logic                  ph_en;
    logic [CFG_DATA_W-1:0] ph_min;
    logic [CFG_DATA_W-1:0] ph_win;

    none = '0;

    // Directed rows, starting from the reset settings with an empty table.
    add_event(mk_event(ACT_TRACK, 32'h0, 48'd1000, 48'd7), 1'b1, 1'b0, 16'd1);
    add_event(mk_event(ACT_TRACK, 32'h0, 48'd2000, 48'd7), 1'b1, 1'b0, 16'd2);
    add_event(mk_event(ACT_TRACK, 32'h0, 48'd3000, 48'd8), 1'b1, 1'b1, 16'd3);
    // Window runs out: the count restarts but the mark stays.
    add_event(mk_event(ACT_TRACK, 32'h0, 48'd13001, 48'd9), 1'b1, 1'b1, 16'd1);
    // A time before the window start does not expire it.
    add_event(mk_event(ACT_TRACK, 32'h0, 48'd500, 48'd9), 1'b1, 1'b1, 16'd2);
    add_event(mk_event(ACT_TRACK, '1, TIME_MAX, TIME_MAX), 1'b1, 1'b0, 16'd1);
    add_event(mk_event(ACT_TRACK, '1, 48'd0, TIME_MAX), 1'b1, 1'b0, 16'd2);
    add_event(mk_event(ACT_CLEAR, '1, TIME_MAX, TIME_MAX), 1'b1, 1'b0, 16'd0);
    add_event(mk_event(ACT_TRACK, 32'h0, 48'd5, 48'd1), 1'b0, 1'b0, 16'd0);
    add_reg(REG_ENABLE, 16'd0);
    add_event(mk_event(ACT_TRACK, 32'h0, 48'd6, 48'd1), 1'b1, 1'b0, 16'd0);
    add_event(mk_event(ACT_CLEAR, 32'h0, 48'd6, 48'd1), 1'b1, 1'b0, 16'd0);
    add_reg(REG_ENABLE, 16'd1);
    add_reg(REG_MIN_COUNT, 16'd1);
    add_event(mk_event(ACT_TRACK, 32'h1234_5678, 48'd10, 48'd2), 1'b1, 1'b1, 16'd1);
    add_reg(REG_MIN_COUNT, 16'd0);
    add_event(mk_event(ACT_TRACK, 32'h8765_4321, 48'd20, 48'd3), 1'b1, 1'b0, 16'd1);
    add_event(mk_event(ACT_TRACK, 32'h8765_4321, 48'd20, 48'd4), 1'b0, 1'b0, 16'd0);
    add_reg(REG_WINDOW_SEC, 16'd0);
    add_event(mk_event(ACT_TRACK, 32'h8765_4321, 48'd21, 48'd5), 1'b0, 1'b0, 16'd0);
    add_event(mk_event(ACT_TRACK, 32'h8765_4321, 48'd21, 48'd6), 1'b0, 1'b0, 16'd0);
    add_reg(REG_WINDOW_SEC, 16'hFFFF);
    add_reg(REG_MIN_COUNT, 16'hFFFF);
    add_event(mk_event(ACT_TRACK, 32'h0, TIME_MAX, 48'd7), 1'b0, 1'b0, 16'd0);
    add_event(mk_event(ACT_TRACK, '1, 48'd1, 48'd8), 1'b0, 1'b0, 16'd0);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_REG) begin
        settle();
        write_reg(directed_rows[r].reg_idx, directed_rows[r].reg_val);
      end else begin
        push_event(directed_rows[r].ev, directed_rows[r].typed, directed_rows[r].want);
      end
    end

    // More keys than slots, so evictions happen throughout the random part.
    foreach (key_pool[k]) key_pool[k] = $urandom;
    key_pool[0] = '0;
    key_pool[1] = '1;
    clock_ms    = 48'd100_000;

    for (int p = 0; p < RAND_PHASES; p++) begin
      settle();
      case (p)
        0: begin ph_en = 1'b1; ph_min = 16'd3;      ph_win = 16'd10;     end
        1: begin ph_en = 1'b1; ph_min = 16'd1;      ph_win = 16'd0;      end
        2: begin ph_en = 1'b1; ph_min = 16'd0;      ph_win = 16'hFFFF;   end
        3: begin ph_en = 1'b1; ph_min = 16'hFFFF;   ph_win = 16'hFFFF;   end
        4: begin ph_en = 1'b0; ph_min = 16'($urandom); ph_win = 16'($urandom); end
        5: begin
          ph_en  = 1'b1;
          ph_min = 16'($urandom_range(2, 6));
          ph_win = 16'($urandom_range(0, 5));
        end
        6: begin ph_en = 1'b1; ph_min = 16'($urandom); ph_win = 16'($urandom); end
        default: begin ph_en = 1'b1; ph_min = 16'd2; ph_win = 16'd1; end
      endcase
      write_reg(REG_ENABLE, {15'd0, ph_en});
      write_reg(REG_MIN_COUNT, ph_min);
      write_reg(REG_WINDOW_SEC, ph_win);

      for (int k = 0; k < PHASE_ITEMS; k++) begin
        n    = p * PHASE_ITEMS + k;
        calm = (n >= 500 && n < 650);
        if (n == 300) settle();
        roll = $urandom_range(0, 99);
        // Mostly a steady clock; repeats make ties on window start, big jumps expire windows.
        if (roll < 20) begin
        end else if (roll < 60) begin
          clock_ms = clock_ms + 48'($urandom_range(1, 1500));
        end else if (roll < 78) begin
          clock_ms = clock_ms + 48'($urandom_range(1000, 12000));
        end else if (roll < 88) begin
          clock_ms = clock_ms + 48'($urandom_range(0, 70_000_000));
        end else if (roll >= 96) begin
          clock_ms = rand48();
        end
        ev.now_ms = (roll >= 88 && roll < 96) ? clock_ms - 48'($urandom_range(0, 5000))
                                              : clock_ms;
        ev.action    = ($urandom_range(0, 99) < 3) ? ACT_CLEAR : ACT_TRACK;
        ev.topic_key = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, KEY_POOL - 1)]
                                                    : TOPIC_W'($urandom);
        ev.detect_stamp_ms = ($urandom_range(0, 1) != 0) ? 48'($urandom_range(0, 3)) : rand48();
        push_event(ev, 1'b0, none);
      end
    end
    calm = 1'b0;
    settle();

    if (fault_cnt == 0) begin
      $display("keyed_event_burst_detector verification clean");
    end else begin
      $display("keyed_event_burst_detector verification failed");
    end
    $finish;
  end

endmodule

// File: keyed_event_burst_detector.f
hw/rtl/kebd_pkg.sv
hw/rtl/kebd_ram.sv
hw/rtl/kebd_core.sv
hw/rtl/keyed_event_burst_detector.sv
test/tb.sv
